[sv/pdsl_pkg.sv]
package pdsl_pkg;

  localparam int CHANNELS_DEF  = 5;
  localparam int DUTY_BITS_DEF = 10;

  localparam int REQ_W     = 2;
  localparam int CH_W      = 3;
  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CALC_W    = FIELD_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CEILING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLEW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEF_STEP = 2'd2;

  localparam logic [CFG_W-1:0] CEILING_RST  = 10'd460;
  localparam logic [CFG_W-1:0] SLEW_RST     = 10'd10;
  localparam logic [CFG_W-1:0] DEF_STEP_RST = 10'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET  = 2'd0,
    REQ_RAMP = 2'd1,
    REQ_GET  = 2'd2,
    REQ_KILL = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_SLEW
  } state_t;

  typedef struct packed {
    req_type_t          req;
    logic               ch_ok;
    logic [FIELD_W-1:0] duty;
    logic [FIELD_W-1:0] step;
  } req_t;

  typedef struct packed {
    logic [CFG_W-1:0] ceiling;
    logic [CFG_W-1:0] slew;
    logic [CFG_W-1:0] def_step;
  } cfg_t;

endpackage

[sv/pwm_duty_slew_limiter_core.sv]
// PWM duty store with ceiling clamp and slew limiter.
// Input channel (in_valid/in_ready): one request per transaction: set, ramp,
// get or kill, with channel, requested duty and ramp step.
// Result channel (out_valid/out_ready): exactly one result per request:
// ok, the channel's duty after the request, and whether a level was written.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 ceiling,
// 1 slew limit, 2 default ramp step; other indexes are dropped. Write only
// while no request is in flight.
// Sequence: the memory read is registered on accept, the ramp step is registered
// in the step state, then clamp, slew, write-back and the result register follow in the slew state.
// Requests do not overlap: the next one is taken only after the read / step /
// write-back sequence ends; in_ready is high only in idle.
// A stalled receiver holds the result register; the write-back waits in the
// last step until the slot frees, so no result is dropped.
// Reset: registers return to their reset values and all channel duties read
// as zero at once (per-entry valid bits); kill clears the same bits.
module pwm_duty_slew_limiter_core #(
  parameter int CHANNELS  = pdsl_pkg::CHANNELS_DEF,
  parameter int DUTY_BITS = pdsl_pkg::DUTY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pdsl_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pdsl_pkg::CH_W-1:0]      in_channel,
  input  logic [pdsl_pkg::FIELD_W-1:0]   in_requested_duty,
  input  logic [pdsl_pkg::FIELD_W-1:0]   in_ramp_step,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [DUTY_BITS-1:0]           out_duty_now,
  output logic                           out_level_written,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdsl_pkg::CFG_W-1:0]     cfg_data
);
  import pdsl_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t               state_r, state_nxt;
  cfg_t                 cfg_r;
  req_t                 req_r;
  logic [AW-1:0]        addr_r;
  logic                 in_ch_ok;
  logic [AW-1:0]        rd_addr;
  logic                 accept, step_en, commit;
  logic [DUTY_BITS-1:0] cur, new_duty;
  logic                 upd_wr, mem_wr, mem_clr, is_kill;
  logic                 out_valid_r, out_ok_r, out_lw_r;
  logic [DUTY_BITS-1:0] out_duty_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ceiling  <= CEILING_RST;
      cfg_r.slew     <= SLEW_RST;
      cfg_r.def_step <= DEF_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_CEILING) begin
        cfg_r.ceiling <= cfg_data;
      end else if (cfg_index == CFG_IDX_SLEW) begin
        cfg_r.slew <= cfg_data;
      end else if (cfg_index == CFG_IDX_DEF_STEP) begin
        cfg_r.def_step <= cfg_data;
      end
    end
  end

  assign in_ch_ok = {1'b0, in_channel} < (CH_W + 1)'(CHANNELS);
  assign rd_addr  = in_ch_ok ? in_channel[AW-1:0] : '0;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        state_nxt = ST_SLEW;
      end
      ST_SLEW: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    step_en  = 1'b0;
    commit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_STEP: begin
        step_en = 1'b1;
      end
      ST_SLEW: begin
        commit = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.req   <= req_type_t'(in_req_type);
      req_r.ch_ok <= in_ch_ok;
      req_r.duty  <= in_requested_duty;
      req_r.step  <= in_ramp_step;
      addr_r      <= rd_addr;
    end
  end

  pdsl_duty_mem #(
    .CHANNELS  (CHANNELS),
    .DUTY_BITS (DUTY_BITS),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (cur),
    .wr_en   (mem_wr),
    .wr_addr (addr_r),
    .wr_data (new_duty),
    .clr     (mem_clr)
  );

  pdsl_update #(
    .DUTY_BITS (DUTY_BITS)
  ) u_update (
    .clk      (clk),
    .step_en  (step_en),
    .req      (req_r),
    .cfg      (cfg_r),
    .cur      (cur),
    .new_duty (new_duty),
    .wr       (upd_wr)
  );

  assign is_kill = (req_r.req == REQ_KILL);
  assign mem_wr  = commit && !is_kill && req_r.ch_ok && upd_wr;
  assign mem_clr = commit && is_kill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ok_r <= is_kill || req_r.ch_ok;
      out_lw_r <= is_kill || (req_r.ch_ok && upd_wr);
      if (is_kill || !req_r.ch_ok) begin
        out_duty_r <= '0;
      end else if (upd_wr) begin
        out_duty_r <= new_duty;
      end else begin
        out_duty_r <= cur;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_duty_now      = out_duty_r;
  assign out_level_written = out_lw_r;

  a_rose_after_slew: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_SLEW)
    else $error("result appeared outside write-back");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_duty_r == '0 && !out_lw_r)
    else $error("rejected request carries data");

  a_written_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lw_r |-> out_ok_r)
    else $error("level written without ok");

  a_mem_wr_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> state_r == ST_SLEW && req_r.ch_ok && !mem_clr)
    else $error("duty write outside write-back");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready ##1 !in_ready)
    else $error("request accepted while busy");

endmodule

[sv/pdsl_duty_mem.sv]
module pdsl_duty_mem #(
  parameter int CHANNELS  = pdsl_pkg::CHANNELS_DEF,
  parameter int DUTY_BITS = pdsl_pkg::DUTY_BITS_DEF,
  parameter int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [DUTY_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [DUTY_BITS-1:0] wr_data,
  input  logic                 clr
);

  logic [DUTY_BITS-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0]  vld_r;
  logic [DUTY_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[sv/pdsl_update.sv]
module pdsl_update #(
  parameter int DUTY_BITS = pdsl_pkg::DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 step_en,
  input  pdsl_pkg::req_t       req,
  input  pdsl_pkg::cfg_t       cfg,
  input  logic [DUTY_BITS-1:0] cur,
  output logic [DUTY_BITS-1:0] new_duty,
  output logic                 wr
);
  import pdsl_pkg::*;

  localparam logic [CALC_W-1:0] DUTY_MASK = CALC_W'((32'd1 << DUTY_BITS) - 32'd1);

  logic [CALC_W-1:0] cur_e, ceil_e, ceil_eff, duty_e, tgt, step_e, up, dn_gap;
  logic [CALC_W-1:0] cand, cand_r, want, slew_e, res;
  logic              cand_wr, cand_wr_r;

  always_comb begin
    cur_e    = CALC_W'(cur);
    ceil_e   = CALC_W'(cfg.ceiling);
    ceil_eff = (ceil_e > DUTY_MASK) ? DUTY_MASK : ceil_e;
    duty_e   = CALC_W'(req.duty);
    tgt      = (duty_e > ceil_eff) ? ceil_eff : duty_e;
    step_e   = (req.step == '0) ? CALC_W'(cfg.def_step) : CALC_W'(req.step);
    up       = cur_e + step_e;
    dn_gap   = cur_e - tgt;
    cand     = cur_e;
    cand_wr  = 1'b0;
    case (req.req)
      REQ_SET: begin
        cand    = tgt;
        cand_wr = 1'b1;
      end
      REQ_RAMP: begin
        if (cur_e < tgt) begin
          cand    = (up > tgt) ? tgt : up;
          cand_wr = 1'b1;
        end else if (cur_e > tgt) begin
          cand    = (dn_gap < step_e) ? tgt : cur_e - step_e;
          cand_wr = 1'b1;
        end
      end
      default: begin
        cand    = cur_e;
        cand_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      cand_r    <= cand;
      cand_wr_r <= cand_wr;
    end
  end

  always_comb begin
    slew_e = CALC_W'(cfg.slew);
    want   = (cand_r > ceil_eff) ? ceil_eff : cand_r;
    res    = want;
    if (want > cur_e && (want - cur_e) > slew_e) begin
      res = cur_e + slew_e;
    end else if (want < cur_e && (cur_e - want) > slew_e) begin
      res = cur_e - slew_e;
    end
  end

  assign new_duty = res[DUTY_BITS-1:0];
  assign wr       = cand_wr_r;

endmodule

[tb/pdsl_duty_checker.sv]
`timescale 1ns / 1ps

module pdsl_duty_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [pdsl_pkg::REQ_W-1:0]          in_req_type,
  input  logic [pdsl_pkg::CH_W-1:0]           in_channel,
  input  logic [pdsl_pkg::FIELD_W-1:0]        in_requested_duty,
  input  logic [pdsl_pkg::FIELD_W-1:0]        in_ramp_step,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_ok,
  input  logic [pdsl_pkg::DUTY_BITS_DEF-1:0]  out_duty_now,
  input  logic                                out_level_written,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [pdsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdsl_pkg::CFG_W-1:0]          cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked
);
  import pdsl_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int DW = DUTY_BITS_DEF;
  localparam int unsigned DUTY_MAX = (1 << DW) - 1;

  typedef struct packed {
    logic          ok;
    logic [DW-1:0] duty;
    logic          written;
  } duty_result_t;

  duty_result_t     expected_duty_q[$];
  logic [DW-1:0]    duty_mem [NCH];
  logic [CFG_W-1:0] ceiling_r;
  logic [CFG_W-1:0] slew_r;
  logic [CFG_W-1:0] def_step_r;
  int               errs = 0;
  int               n_checked = 0;

  function automatic int unsigned clamp_to_ceiling(int unsigned v);
    int unsigned c;
    c = ceiling_r;
    if (c > DUTY_MAX) c = DUTY_MAX;
    return (v > c) ? c : v;
  endfunction

  function automatic void slew_and_store(int unsigned ch, int unsigned v);
    int unsigned want;
    int unsigned cur;
    want = clamp_to_ceiling(v);
    cur = duty_mem[ch];
    if (want > cur && want - cur > slew_r) begin
      want = cur + slew_r;
    end else if (want < cur && cur - want > slew_r) begin
      want = cur - slew_r;
    end
    duty_mem[ch] = want[DW-1:0];
  endfunction

  function automatic duty_result_t apply_request(req_type_t rq, logic [CH_W-1:0] ch,
                                                 logic [FIELD_W-1:0] duty,
                                                 logic [FIELD_W-1:0] step);
    duty_result_t r;
    int unsigned  tgt;
    int unsigned  cur;
    int unsigned  stp;
    int unsigned  nxt;
    r = '0;
    if (rq == REQ_KILL) begin
      foreach (duty_mem[i]) duty_mem[i] = '0;
      r.ok = 1'b1;
      r.written = 1'b1;
    end else if (ch < NCH) begin
      r.ok = 1'b1;
      if (rq == REQ_SET) begin
        slew_and_store(ch, duty);
        r.written = 1'b1;
      end else if (rq == REQ_RAMP) begin
        tgt = clamp_to_ceiling(duty);
        cur = duty_mem[ch];
        stp = (step == 0) ? def_step_r : step;
        if (cur < tgt) begin
          nxt = cur + stp;
          if (nxt > tgt) nxt = tgt;
          slew_and_store(ch, nxt);
          r.written = 1'b1;
        end else if (cur > tgt) begin
          nxt = (cur - tgt < stp) ? tgt : cur - stp;
          slew_and_store(ch, nxt);
          r.written = 1'b1;
        end
      end
      r.duty = duty_mem[ch];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    duty_result_t want;
    if (!rst_n) begin
      expected_duty_q.delete();
      foreach (duty_mem[i]) duty_mem[i] = '0;
      ceiling_r = CEILING_RST;
      slew_r = SLEW_RST;
      def_step_r = DEF_STEP_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_duty_q.size() == 0) begin
          $error("unexpected transaction: ok=%0d duty_now=%0d level_written=%0d",
                 out_ok, out_duty_now, out_level_written);
          errs++;
        end else begin
          want = expected_duty_q.pop_front();
          n_checked++;
          if (out_ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_ok);
            errs++;
          end
          if (out_duty_now !== want.duty) begin
            $error("duty_now: expected %0d, got %0d", want.duty, out_duty_now);
            errs++;
          end
          if (out_level_written !== want.written) begin
            $error("level_written: expected %0d, got %0d", want.written, out_level_written);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_CEILING:  ceiling_r = cfg_data;
          CFG_IDX_SLEW:     slew_r = cfg_data;
          CFG_IDX_DEF_STEP: def_step_r = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_duty_q.push_back(apply_request(req_type_t'(in_req_type), in_channel,
                                                in_requested_duty, in_ramp_step));
      end
    end
    fail_count <= errs;
    pending <= expected_duty_q.size();
    checked <= n_checked;
  end

endmodule

[tb/tb_pwm_duty_slew_limiter_core.sv]
`timescale 1ns / 1ps

module tb_pwm_duty_slew_limiter_core;
  import pdsl_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int DW = DUTY_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 222;
  localparam int CYCLE_LIMIT = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [CH_W-1:0]      in_channel = '0;
  logic [FIELD_W-1:0]   in_requested_duty = '0;
  logic [FIELD_W-1:0]   in_ramp_step = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_ok;
  logic [DW-1:0]        out_duty_now;
  logic                 out_level_written;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int               fail_count;
  int               pending;
  int               checked;
  int               cycles = 0;
  int unsigned      send_idle_pct = 26;
  int unsigned      recv_idle_pct = 67;
  int               n_sent = 0;
  int               n_kill = 0;
  int               n_reject = 0;
  logic [CFG_W-1:0] cur_ceiling = CEILING_RST;

  always #5 clk = ~clk;

  pwm_duty_slew_limiter_core #(
    .CHANNELS  (NCH),
    .DUTY_BITS (DW)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_channel        (in_channel),
    .in_requested_duty (in_requested_duty),
    .in_ramp_step      (in_ramp_step),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_duty_now      (out_duty_now),
    .out_level_written (out_level_written),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  pdsl_duty_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_channel        (in_channel),
    .in_requested_duty (in_requested_duty),
    .in_ramp_step      (in_ramp_step),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_duty_now      (out_duty_now),
    .out_level_written (out_level_written),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_req(req_type_t rq, logic [CH_W-1:0] ch, logic [FIELD_W-1:0] duty,
                          logic [FIELD_W-1:0] step);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_channel <= ch;
    in_requested_duty <= duty;
    in_ramp_step <= step;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (rq == REQ_KILL) n_kill++;
    else if (ch >= NCH) n_reject++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // spare index goes first and must be dropped by the block
  task automatic load_config(logic [CFG_W-1:0] ceil_v, logic [CFG_W-1:0] slew_v,
                             logic [CFG_W-1:0] step_v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     val [4];
    idx = '{CFG_IDX_SPARE, CFG_IDX_CEILING, CFG_IDX_SLEW, CFG_IDX_DEF_STEP};
    val = '{CFG_W'($urandom), ceil_v, slew_v, step_v};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_ceiling = ceil_v;
  endtask

  function automatic logic [FIELD_W-1:0] pick_duty();
    case ($urandom_range(3))
      0:       return FIELD_W'($urandom);
      1:       return FIELD_W'($urandom_range(1023));
      2:       return FIELD_W'(cur_ceiling) + FIELD_W'($urandom_range(4)) - FIELD_W'(2);
      default: return FIELD_W'($urandom_range(30));
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_step();
    case ($urandom_range(3))
      0:       return '0;
      1:       return FIELD_W'($urandom_range(1, 40));
      2:       return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(1, 1023));
    endcase
  endfunction

  task automatic send_random();
    int unsigned      r;
    req_type_t        rq;
    logic [CH_W-1:0]  ch;
    r = $urandom_range(99);
    if (r < 30) rq = REQ_SET;
    else if (r < 60) rq = REQ_RAMP;
    else if (r < 93) rq = REQ_GET;
    else rq = REQ_KILL;
    if ($urandom_range(99) < 12) ch = CH_W'($urandom_range(7, NCH));
    else ch = CH_W'($urandom_range(NCH - 1));
    send_req(rq, ch, pick_duty(), pick_step());
  endtask

  initial begin
    logic [CFG_W-1:0] ceil_tab [PHASES];
    logic [CFG_W-1:0] slew_tab [PHASES];
    logic [CFG_W-1:0] step_tab [PHASES];
    logic [CH_W-1:0]  ch;
    logic [FIELD_W-1:0] tgt;
    int               len;
    int               sent;
    ceil_tab = '{10'd1023, 10'd0,   10'd300, 10'd777, 10'd0, 10'd460};
    slew_tab = '{10'd1023, 10'd1,   10'd0,   10'd50,  10'd0, 10'd10};
    step_tab = '{10'd1023, 10'd0,   10'd7,   10'd1023, 10'd0, 10'd1};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: clamp at 460, slew 10, default step 1
    send_req(REQ_SET,  3'd0, 16'hFFFF, 16'hFFFF);
    send_req(REQ_SET,  3'd0, 16'h0000, 16'h0000);
    send_req(REQ_SET,  3'd0, 16'h0000, 16'h0000);
    send_req(REQ_RAMP, 3'd1, 16'd1000, 16'h0000);
    send_req(REQ_RAMP, 3'd1, 16'hFFFF, 16'hFFFF);
    send_req(REQ_RAMP, 3'd1, 16'h0000, 16'd3);
    send_req(REQ_RAMP, 3'd2, 16'h0000, 16'd5);
    send_req(REQ_GET,  3'd1, 16'h0000, 16'h0000);
    send_req(REQ_SET,  3'd4, 16'd460,  16'h0001);
    send_req(REQ_SET,  3'd5, 16'd100,  16'h0000);
    send_req(REQ_RAMP, 3'd6, 16'd200,  16'd4);
    send_req(REQ_GET,  3'd7, 16'hFFFF, 16'hFFFF);
    send_req(REQ_KILL, 3'd7, 16'hFFFF, 16'hFFFF);
    send_req(REQ_GET,  3'd4, 16'h0000, 16'h0000);
    send_req(REQ_SET,  3'd3, 16'hAAAA, 16'h5555);
    send_req(REQ_SET,  3'd3, 16'h5555, 16'hAAAA);
    send_req(REQ_RAMP, 3'd3, 16'h1234, 16'h8000);
    send_req(REQ_RAMP, 3'd3, 16'd5,    16'h0000);
    send_req(REQ_GET,  3'd2, 16'h0000, 16'h0000);
    send_req(REQ_KILL, 3'd0, 16'h0000, 16'h0000);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        load_config(CFG_W'($urandom_range(1, 1023)), CFG_W'($urandom_range(1, 200)),
                    CFG_W'($urandom_range(1023)));
      end else begin
        load_config(ceil_tab[p], slew_tab[p], step_tab[p]);
      end
      case (p / 2)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 40) begin
          // run one channel toward a fixed target
          ch = CH_W'($urandom_range(NCH - 1));
          tgt = pick_duty();
          len = $urandom_range(2, 8);
          for (int k = 0; k < len; k++) begin
            send_req(($urandom_range(3) == 0) ? REQ_SET : REQ_RAMP, ch, tgt, pick_step());
          end
          sent += len;
        end else begin
          send_random();
          sent++;
        end
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("%0d requests sent (%0d kills, %0d rejected channels), %0d results compared",
             n_sent, n_kill, n_reject, checked);
    $display("register sets: reset, both extremes, zero slew, random; stalls on both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/pdsl_pkg.sv
sv/pdsl_duty_mem.sv
sv/pdsl_update.sv
sv/pwm_duty_slew_limiter_core.sv
tb/pdsl_duty_checker.sv
tb/tb_pwm_duty_slew_limiter_core.sv
